/* sv/fraction_mixed_number_reducer_unit_macros.svh */
// assertion macros for the fraction reducer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef FRACTION_MIXED_NUMBER_REDUCER_UNIT_MACROS_SVH
`define FRACTION_MIXED_NUMBER_REDUCER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FMR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fmr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define FMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fmr assertion failed");

`endif

/* sv/fmr_pkg.sv */
// shared types and constants of the fraction reducer
// no dependencies; used by every module of the block
`default_nettype none

package fmr_pkg;

  localparam int DATA_WIDTH = 31;
  localparam int SHIFT_W    = $clog2(DATA_WIDTH);
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;

  // input beat
  typedef struct packed {
    data_t numerator;
    data_t denominator;
  } req_t;

  // result beat
  typedef struct packed {
    logic  whole_valid;
    data_t whole_part;
    logic  fraction_valid;
    data_t reduced_numerator;
    data_t reduced_denominator;
  } res_t;

  // which division the shared divider performs
  typedef enum logic [1:0] {
    DIV_WHOLE,
    DIV_NUM,
    DIV_DEN
  } div_sel_e;

  // one step of the binary gcd
  typedef enum logic [2:0] {
    GCD_NONE,
    GCD_HALVE_BOTH,
    GCD_HALVE_A,
    GCD_HALVE_B,
    GCD_SUBTRACT,
    GCD_FINISH
  } gcd_op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_WHOLE,
    ST_TEST,
    ST_GCD_TWOS,
    ST_GCD_AODD,
    ST_GCD_LOOP,
    ST_START_NUM,
    ST_DIV_NUM,
    ST_START_DEN,
    ST_DIV_DEN,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_step;
    logic     gcd_init;
    gcd_op_e  gcd_op;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic num_gt_den;
    logic div_last;
    logic a_even;
    logic b_even;
    logic b_zero;
  } status_t;

endpackage

`default_nettype wire

/* sv/fmr_datapath.sv */
// datapath: operand registers, bit-serial divider, binary gcd unit, result registers
// depends on fmr_pkg
`default_nettype none

module fmr_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fmr_pkg::req_t   req_i,
  input  wire fmr_pkg::cmd_t   cmd_i,
  output fmr_pkg::status_t     status_o,
  output fmr_pkg::res_t        result_o
);

  localparam int W = fmr_pkg::DATA_WIDTH;

  // operands
  fmr_pkg::data_t num_q, den_q;
  // gcd working registers
  fmr_pkg::data_t a_q, b_q, g_q;
  logic [fmr_pkg::SHIFT_W-1:0] shift_q;
  // divider
  fmr_pkg::data_t rem_q, quo_q, dvs_q;
  logic [fmr_pkg::CNT_W-1:0] cnt_q;
  fmr_pkg::div_sel_e sel_q;
  // results
  logic           whole_valid_q, frac_valid_q;
  fmr_pkg::data_t whole_q, rnum_q, rden_q;

  // one restoring divide step
  logic [W:0]     trial;
  logic           ge;
  logic [W:0]     rem_nx;
  fmr_pkg::data_t quo_nx;

  always_comb begin
    trial  = {rem_q, quo_q[W-1]};
    ge     = (trial >= {1'b0, dvs_q});
    rem_nx = ge ? (trial - {1'b0, dvs_q}) : trial;
    quo_nx = {quo_q[W-2:0], ge};
  end

  // divider iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= fmr_pkg::CNT_W'(W);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - fmr_pkg::CNT_W'(1);
    end
  end

  // divider operands and partial results
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      sel_q <= cmd_i.div_sel;
      rem_q <= '0;
      unique case (cmd_i.div_sel)
        fmr_pkg::DIV_WHOLE: begin
          quo_q <= num_q;
          dvs_q <= den_q;
        end
        fmr_pkg::DIV_NUM: begin
          quo_q <= num_q;
          dvs_q <= g_q;
        end
        fmr_pkg::DIV_DEN: begin
          quo_q <= den_q;
          dvs_q <= g_q;
        end
        default: begin
          quo_q <= num_q;
          dvs_q <= den_q;
        end
      endcase
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nx[W-1:0];
      quo_q <= quo_nx;
    end
  end

  // operand load and whole-part remainder write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= req_i.numerator;
      den_q <= req_i.denominator;
    end else if (cmd_i.div_step && status_o.div_last && sel_q == fmr_pkg::DIV_WHOLE) begin
      num_q <= rem_nx[W-1:0];
    end
  end

  // result registers, cleared at load so unused fields read zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      whole_valid_q <= 1'b0;
      whole_q       <= '0;
      frac_valid_q  <= 1'b0;
      rnum_q        <= '0;
      rden_q        <= '0;
    end else if (cmd_i.div_step && status_o.div_last) begin
      unique case (sel_q)
        fmr_pkg::DIV_WHOLE: begin
          whole_valid_q <= 1'b1;
          whole_q       <= quo_nx;
        end
        fmr_pkg::DIV_NUM: begin
          rnum_q <= quo_nx;
        end
        fmr_pkg::DIV_DEN: begin
          rden_q       <= quo_nx;
          frac_valid_q <= 1'b1;
        end
        default: begin
          rnum_q <= rnum_q;
        end
      endcase
    end
  end

  // binary gcd, one step a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      a_q     <= num_q;
      b_q     <= den_q;
      shift_q <= '0;
    end else begin
      unique case (cmd_i.gcd_op)
        fmr_pkg::GCD_NONE: begin
          a_q <= a_q;
        end
        fmr_pkg::GCD_HALVE_BOTH: begin
          a_q     <= a_q >> 1;
          b_q     <= b_q >> 1;
          shift_q <= shift_q + fmr_pkg::SHIFT_W'(1);
        end
        fmr_pkg::GCD_HALVE_A: begin
          a_q <= a_q >> 1;
        end
        fmr_pkg::GCD_HALVE_B: begin
          b_q <= b_q >> 1;
        end
        fmr_pkg::GCD_SUBTRACT: begin
          // keep the smaller in a, the difference in b
          if (a_q > b_q) begin
            a_q <= b_q;
            b_q <= a_q - b_q;
          end else begin
            b_q <= b_q - a_q;
          end
        end
        fmr_pkg::GCD_FINISH: begin
          g_q <= a_q << shift_q;
        end
        default: begin
          a_q <= a_q;
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    status_o.den_zero   = (den_q == '0);
    status_o.num_zero   = (num_q == '0);
    status_o.num_gt_den = (num_q > den_q);
    status_o.div_last   = (cnt_q == fmr_pkg::CNT_W'(1));
    status_o.a_even     = ~a_q[0];
    status_o.b_even     = ~b_q[0];
    status_o.b_zero     = (b_q == '0);
  end

  // result beat
  always_comb begin
    result_o.whole_valid         = whole_valid_q;
    result_o.whole_part          = whole_q;
    result_o.fraction_valid      = frac_valid_q;
    result_o.reduced_numerator   = rnum_q;
    result_o.reduced_denominator = rden_q;
  end

endmodule

`default_nettype wire

/* sv/fmr_ctrl.sv */
// controller state machine sequencing divide, gcd and the two exact divides
// depends on fmr_pkg
`default_nettype none

module fmr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire fmr_pkg::status_t status_i,
  output fmr_pkg::cmd_t         cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  fmr_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = fmr_pkg::DIV_WHOLE;
    cmd_o.div_step  = 1'b0;
    cmd_o.gcd_init  = 1'b0;
    cmd_o.gcd_op    = fmr_pkg::GCD_NONE;
    busy_o          = (state_q != fmr_pkg::ST_IDLE);
    done_o          = (state_q == fmr_pkg::ST_DONE);
    unique case (state_q)
      fmr_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = fmr_pkg::ST_CHECK;
        end
      end
      fmr_pkg::ST_CHECK: begin
        if (status_i.den_zero) begin
          state_d = fmr_pkg::ST_DONE;
        end else if (status_i.num_gt_den) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = fmr_pkg::DIV_WHOLE;
          state_d         = fmr_pkg::ST_DIV_WHOLE;
        end else begin
          state_d = fmr_pkg::ST_TEST;
        end
      end
      fmr_pkg::ST_DIV_WHOLE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = fmr_pkg::ST_TEST;
        end
      end
      fmr_pkg::ST_TEST: begin
        if (status_i.num_zero) begin
          state_d = fmr_pkg::ST_DONE;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = fmr_pkg::ST_GCD_TWOS;
        end
      end
      // strip common factors of two
      fmr_pkg::ST_GCD_TWOS: begin
        if (status_i.a_even && status_i.b_even) begin
          cmd_o.gcd_op = fmr_pkg::GCD_HALVE_BOTH;
        end else begin
          state_d = fmr_pkg::ST_GCD_AODD;
        end
      end
      // make a odd
      fmr_pkg::ST_GCD_AODD: begin
        if (status_i.a_even) begin
          cmd_o.gcd_op = fmr_pkg::GCD_HALVE_A;
        end else begin
          state_d = fmr_pkg::ST_GCD_LOOP;
        end
      end
      // subtract-and-halve loop
      fmr_pkg::ST_GCD_LOOP: begin
        if (status_i.b_zero) begin
          cmd_o.gcd_op = fmr_pkg::GCD_FINISH;
          state_d      = fmr_pkg::ST_START_NUM;
        end else if (status_i.b_even) begin
          cmd_o.gcd_op = fmr_pkg::GCD_HALVE_B;
        end else begin
          cmd_o.gcd_op = fmr_pkg::GCD_SUBTRACT;
        end
      end
      fmr_pkg::ST_START_NUM: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = fmr_pkg::DIV_NUM;
        state_d         = fmr_pkg::ST_DIV_NUM;
      end
      fmr_pkg::ST_DIV_NUM: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = fmr_pkg::ST_START_DEN;
        end
      end
      fmr_pkg::ST_START_DEN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = fmr_pkg::DIV_DEN;
        state_d         = fmr_pkg::ST_DIV_DEN;
      end
      fmr_pkg::ST_DIV_DEN: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = fmr_pkg::ST_DONE;
        end
      end
      fmr_pkg::ST_DONE: begin
        state_d = fmr_pkg::ST_IDLE;
      end
      default: begin
        state_d = fmr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/fraction_mixed_number_reducer_unit.sv */
// Fraction reducer to mixed-number form. A beat is taken when start_i is high and
// busy_o is low; one item is worked on at a time. The result is shown on result_o
// for exactly one cycle with done_o high and cannot be held off by the receiver,
// so it must be captured in that cycle. A whole-part divide runs first when the
// numerator exceeds the denominator; then, when a fraction remains, the binary gcd
// and the two exact divides follow. A zero denominator skips all arithmetic. In the
// cycle after the strobe the block is idle again and can take the next beat. The
// cost is set by the shared bit-serial divider (one quotient bit a cycle) and the
// binary gcd (one halving or subtraction a cycle).
// depends on fmr_pkg, fmr_ctrl and fmr_datapath
`default_nettype none

module fraction_mixed_number_reducer_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire fmr_pkg::req_t  in_i,
  output logic                busy_o,
  output logic                done_o,
  output fmr_pkg::res_t       result_o
);

  fmr_pkg::cmd_t    cmd;
  fmr_pkg::status_t status;

  // sequencer
  fmr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // arithmetic
  fmr_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

/* sv/fmr_checker.sv */
// port-level checker for the fraction reducer, bound to the top level
// depends on fmr_pkg and fraction_mixed_number_reducer_unit_macros.svh
`default_nettype none

`include "fraction_mixed_number_reducer_unit_macros.svh"

module fmr_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_o,
  input wire logic          done_o,
  input wire fmr_pkg::res_t result_o
);

  // an accepted beat makes the block busy
  `FMR_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_o, busy_o)

  // result strobe lasts one cycle
  `FMR_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // no whole part means a zero whole field
  `FMR_ASSERT_IMPL(a_whole_zero, clk_i, rst_ni, done_o && !result_o.whole_valid,
                   result_o.whole_part == '0)

  // a reported fraction has a non-zero numerator and denominator
  `FMR_ASSERT_IMPL(a_frac_nonzero, clk_i, rst_ni, done_o && result_o.fraction_valid,
                   (result_o.reduced_denominator != '0) && (result_o.reduced_numerator != '0))

endmodule

bind fraction_mixed_number_reducer_unit fmr_checker u_fmr_checker (.*);

`default_nettype wire

/* tb/sv/fraction_mixed_number_reducer_unit_test.sv */
// self-checking testbench of the fraction reducer: directed table, then random beats
// checked against a mixed-number / gcd predictor; depends on fmr_pkg and the unit itself
`default_nettype none

module fraction_mixed_number_reducer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH = fmr_pkg::DATA_WIDTH;
  typedef fmr_pkg::data_t data_t;
  typedef fmr_pkg::req_t  req_t;
  typedef fmr_pkg::res_t  res_t;

  localparam data_t DMAX       = '1;
  localparam int    RAND_BEATS = 1000;
  localparam int    TAIL_WAIT  = 250;

  // one row of the directed table
  typedef struct {
    req_t beat;
    bit   typed;
    res_t want;
  } vector_t;

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  req_t  in_i;
  logic  busy_o;
  logic  done_o;
  res_t  result_o;

  res_t        pending_q[$];
  vector_t     directed_rows[$];
  int unsigned mismatch_count;

  fraction_mixed_number_reducer_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // whole part by division, remainder reduced by the euclidean gcd
  function automatic res_t reduce_fraction(input req_t r);
    res_t  o;
    data_t rem;
    data_t p;
    data_t q;
    data_t t;
    o   = '0;
    rem = r.numerator;
    if (r.denominator != '0) begin
      if (rem > r.denominator) begin
        o.whole_valid = 1'b1;
        o.whole_part  = rem / r.denominator;
        rem           = rem % r.denominator;
      end
      if (rem != '0) begin
        p = rem;
        q = r.denominator;
        while (q != '0) begin
          t = p % q;
          p = q;
          q = t;
        end
        o.fraction_valid      = 1'b1;
        o.reduced_numerator   = rem / p;
        o.reduced_denominator = r.denominator / p;
      end
    end
    return o;
  endfunction

  // random value of a random bit length, full width now and then
  function automatic data_t rand_bits(input int unsigned w);
    data_t v;
    v = data_t'($urandom);
    if (w < DATA_WIDTH) v &= (data_t'(1) << w) - data_t'(1);
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic add_row(input data_t num, input data_t den, input bit typed,
                         input res_t want);
    vector_t row;
    row.beat.numerator   = num;
    row.beat.denominator = den;
    row.typed            = typed;
    row.want             = want;
    directed_rows.push_back(row);
  endtask

  // called at a falling edge; returns just after the accepting rising edge
  task automatic drive_beat(input req_t beat, input res_t want);
    in_i    = beat;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_q.push_back(want);
  endtask

  // sender gap of geometric length, taken at the next falling edge
  task automatic sender_gap(input int unsigned idle_pct);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      in_i    = req_t'({$urandom, $urandom});
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
      @(negedge clk_i);
    end
  endtask

  // random beat, weighted towards the interesting shapes
  function automatic req_t random_beat();
    req_t            r;
    longint unsigned prod;
    data_t           g;
    r.denominator = rand_bits($urandom_range(1, DATA_WIDTH));
    if (r.denominator == '0) r.denominator = data_t'(1);
    r.numerator = rand_bits($urandom_range(1, DATA_WIDTH));
    case ($urandom_range(9))
      0: r.numerator = '0;
      1: r.numerator = r.denominator;
      2: begin
        prod = longint'(r.denominator) * $urandom_range(2, 40);
        r.numerator = (prod > DMAX) ? r.denominator : data_t'(prod);
      end
      3, 4: begin
        // shared factor so the gcd has real work to do
        g = rand_bits($urandom_range(1, 16));
        if (g == '0) g = data_t'(1);
        r.numerator   = rand_bits($urandom_range(1, 14)) * g;
        r.denominator = rand_bits($urandom_range(1, 14)) * g;
        if (r.denominator == '0) r.denominator = g;
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", result_o));
      end else begin
        want = pending_q.pop_front();
        if (result_o.whole_valid !== want.whole_valid)
          report_mismatch($sformatf("whole_valid got %b want %b",
                                    result_o.whole_valid, want.whole_valid));
        if (result_o.whole_part !== want.whole_part)
          report_mismatch($sformatf("whole_part got %0d want %0d",
                                    result_o.whole_part, want.whole_part));
        if (result_o.fraction_valid !== want.fraction_valid)
          report_mismatch($sformatf("fraction_valid got %b want %b",
                                    result_o.fraction_valid, want.fraction_valid));
        if (result_o.reduced_numerator !== want.reduced_numerator)
          report_mismatch($sformatf("reduced_numerator got %0d want %0d",
                                    result_o.reduced_numerator, want.reduced_numerator));
        if (result_o.reduced_denominator !== want.reduced_denominator)
          report_mismatch($sformatf("reduced_denominator got %0d want %0d",
                                    result_o.reduced_denominator,
                                    want.reduced_denominator));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned idle_pct[4];
    req_t        beat;
    res_t        want;
    mismatch_count = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    in_i           = '0;
    idle_pct       = '{0, 54, 0, 11};

    // directed table: typed rows carry an obvious answer, the rest use the predictor
    add_row('0, data_t'(1), 1'b1, '0);
    add_row('0, DMAX, 1'b1, '0);
    add_row(data_t'(5), '0, 1'b1, '0);
    add_row('0, '0, 1'b1, '0);
    add_row(data_t'(1), data_t'(1), 1'b1, '{1'b0, '0, 1'b1, data_t'(1), data_t'(1)});
    add_row(DMAX, DMAX, 1'b1, '{1'b0, '0, 1'b1, data_t'(1), data_t'(1)});
    add_row(DMAX, data_t'(1), 1'b1, '{1'b1, DMAX, 1'b0, '0, '0});
    add_row(data_t'(1), DMAX, 1'b1, '{1'b0, '0, 1'b1, data_t'(1), DMAX});
    add_row(DMAX, data_t'(2), 1'b1, '{1'b1, DMAX >> 1, 1'b1, data_t'(1), data_t'(2)});
    add_row(data_t'(2), data_t'(1), 1'b1, '{1'b1, data_t'(2), 1'b0, '0, '0});
    add_row(data_t'(1), data_t'(2), 1'b1, '{1'b0, '0, 1'b1, data_t'(1), data_t'(2)});
    add_row(data_t'(12), data_t'(4), 1'b1, '{1'b1, data_t'(3), 1'b0, '0, '0});
    add_row(data_t'(6), data_t'(4), 1'b1, '{1'b1, data_t'(1), 1'b1, data_t'(1), data_t'(2)});
    add_row(data_t'(4), data_t'(6), 1'b1, '{1'b0, '0, 1'b1, data_t'(2), data_t'(3)});
    add_row(data_t'(32'h4000_0000), data_t'(32'h2000_0000), 1'b1,
            '{1'b1, data_t'(2), 1'b0, '0, '0});
    add_row(data_t'(3), data_t'(32'h4000_0000), 1'b0, '0);
    add_row(data_t'(32'h7FFF_FFFE), DMAX, 1'b0, '0);
    add_row(data_t'(32'h7FFF_FFF0), data_t'(32'h3FFF_FFF8), 1'b0, '0);
    add_row(data_t'(32'h5555_5555), data_t'(32'h2AAA_AAAB), 1'b0, '0);
    add_row(data_t'(32'h6000_0000), data_t'(32'h4800_0000), 1'b0, '0);
    add_row(data_t'(32'h4000_0000), data_t'(32'h0030_0000), 1'b0, '0);
    add_row(data_t'(1000), data_t'(1001), 1'b0, '0);
    add_row(data_t'(32'h2AAA_AAAA), data_t'(32'h5555_5555), 1'b0, '0);

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want
                                    : reduce_fraction(directed_rows[i].beat);
      drive_beat(directed_rows[i].beat, want);
      sender_gap(30);
    end

    // random phases, draining the block between them
    for (int phase = 0; phase < 4; phase++) begin
      start_i = 1'b0;
      wait (pending_q.size() == 0);
      @(negedge clk_i);
      for (int n = 0; n < RAND_BEATS / 4; n++) begin
        beat = random_beat();
        drive_beat(beat, reduce_fraction(beat));
        sender_gap(idle_pct[phase]);
      end
    end
    start_i = 1'b0;

    wait (pending_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("fraction_mixed_number_reducer_unit verification clean");
    end else begin
      $display("fraction_mixed_number_reducer_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("fraction_mixed_number_reducer_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire
